[hw/rtl/cqfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cqfp_pkg;

   // Arithmetic path select. The unused code behaves as the normal path.
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_32X32  = 2'd1;
   localparam logic [1:0] MODE_HBD    = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_ROUND_DC   = 3'd1;
   localparam logic [2:0] REG_ROUND_AC   = 3'd2;
   localparam logic [2:0] REG_QUANT_DC   = 3'd3;
   localparam logic [2:0] REG_QUANT_AC   = 3'd4;
   localparam logic [2:0] REG_DEQUANT_DC = 3'd5;
   localparam logic [2:0] REG_DEQUANT_AC = 3'd6;

   localparam int COEFF_W = 32;
   localparam int PARAM_W = 16;
   localparam int POS_W   = 10;
   localparam int EOB_W   = 11;
   localparam int T_W     = 33;   // rounded magnitude, exact in the high bit depth path
   localparam int M_W     = 33;   // quantized magnitude after the shift
   localparam int Q_W     = 34;   // signed quantized value
   localparam int P_W     = 48;   // product of the quantized value and the dequant step

   localparam logic [EOB_W-1:0] MAX_COEFFS = 11'd1024;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [PARAM_W-1:0] round_dc;
      logic signed [PARAM_W-1:0] round_ac;
      logic signed [PARAM_W-1:0] quant_dc;
      logic signed [PARAM_W-1:0] quant_ac;
      logic signed [PARAM_W-1:0] dequant_dc;
      logic signed [PARAM_W-1:0] dequant_ac;
   } cfg_type;

   // One classified coefficient on its way from the front end to the back end.
   typedef struct packed {
      logic signed [T_W-1:0]     t;
      logic signed [PARAM_W-1:0] quant;
      logic signed [PARAM_W-1:0] dequant;
      logic                      neg;
      logic                      half_mode;
      logic [POS_W-1:0]          pos;
      logic                      first;
      logic                      last;
   } work_type;

endpackage

`default_nettype wire

[hw/rtl/cqfp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cqfp_front (
   input  cqfp_pkg::cfg_type                    cfg,
   input  logic signed [cqfp_pkg::COEFF_W-1:0]  coeff,
   input  logic [cqfp_pkg::POS_W-1:0]           scan_pos,
   input  logic                                 first,
   input  logic                                 last,
   output cqfp_pkg::work_type                   item
);
   import cqfp_pkg::*;

   logic                      hbd;
   logic                      half_mode;
   logic signed [PARAM_W-1:0] rnd;
   logic signed [PARAM_W-1:0] qnt;
   logic signed [PARAM_W-1:0] dqs;
   logic signed [T_W-1:0]     cx;
   logic [T_W-1:0]            mag;
   logic                      neg;
   logic signed [PARAM_W:0]   rnd_inc;
   logic signed [PARAM_W:0]   rnd_eff;
   logic signed [T_W:0]       sum;
   logic signed [T_W:0]       mag_s;
   logic signed [T_W:0]       thr;
   logic signed [T_W-1:0]     t_sat;
   logic signed [T_W-1:0]     t_sel;
   logic                      dead;

   assign hbd       = (cfg.mode == MODE_HBD);
   assign half_mode = (cfg.mode == MODE_32X32);

   assign rnd = first ? cfg.round_dc   : cfg.round_ac;
   assign qnt = first ? cfg.quant_dc   : cfg.quant_ac;
   assign dqs = first ? cfg.dequant_dc : cfg.dequant_ac;

   // The narrow paths see only the low 16 bits of the coefficient.
   assign cx  = hbd ? {coeff[COEFF_W-1], coeff}
                    : {{(T_W-16){coeff[15]}}, coeff[15:0]};
   assign neg = cx[T_W-1];
   assign mag = neg ? T_W'(-cx) : T_W'(cx);

   // The 32x32 path rounds with half the offset, rounded toward plus infinity.
   assign rnd_inc = {rnd[PARAM_W-1], rnd} + (PARAM_W+1)'(1);
   assign rnd_eff = half_mode ? (rnd_inc >>> 1) : $signed({rnd[PARAM_W-1], rnd});

   assign mag_s = {1'b0, mag};
   assign sum   = mag_s + {{(T_W-PARAM_W){rnd_eff[PARAM_W]}}, rnd_eff};

   always_comb begin
      if (sum > (T_W+1)'(32767)) begin
         t_sat = T_W'(32767);
      end else if (sum < -(T_W+1)'(32768)) begin
         t_sat = -T_W'(32768);
      end else begin
         t_sat = sum[T_W-1:0];
      end
   end

   assign t_sel = hbd ? sum[T_W-1:0] : t_sat;

   // Dead zone of the 32x32 path: magnitudes below a quarter step quantize to zero.
   assign thr  = $signed({{(T_W+1-PARAM_W){dqs[PARAM_W-1]}}, dqs}) >>> 2;
   assign dead = half_mode && (mag_s < thr);

   always_comb begin
      item.t         = dead ? '0 : t_sel;
      item.quant     = qnt;
      item.dequant   = dqs;
      item.neg       = neg;
      item.half_mode = half_mode;
      item.pos       = scan_pos;
      item.first     = first;
      item.last      = last;
   end

endmodule

`default_nettype wire

[hw/rtl/cqfp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module cqfp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  cqfp_pkg::work_type  wr_data,
   output logic                full,
   input  logic                rd_en,
   output cqfp_pkg::work_type  rd_data,
   output logic                empty
);
   import cqfp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/cqfp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cqfp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cqfp_pkg::work_type                   item,
   input  logic                                 item_avail,
   output logic                                 item_take,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [cqfp_pkg::COEFF_W-1:0]  qcoeff,
   output logic signed [cqfp_pkg::COEFF_W-1:0]  dqcoeff,
   output logic [cqfp_pkg::EOB_W-1:0]           eob,
   output logic                                 block_end
);
   import cqfp_pkg::*;

   logic signed [T_W+PARAM_W-1:0] prod1;
   logic signed [M_W-1:0]         m_in;
   logic                          advance;

   // Stage one: magnitude product and shift.
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [M_W-1:0]     s1_m_ff;
   logic signed [PARAM_W-1:0] s1_dqs_ff;
   logic                      s1_neg_ff;
   logic                      s1_half_ff;
   logic [POS_W-1:0]          s1_pos_ff;
   logic                      s1_first_ff;
   logic                      s1_last_ff;

   // Stage two: the result waiting for its transfer.
   logic                      out_valid_ff, out_valid_in;
   logic signed [COEFF_W-1:0] out_q_ff, out_q_in;
   logic signed [COEFF_W-1:0] out_dq_ff, out_dq_in;
   logic [EOB_W-1:0]          out_eob_ff, out_eob_in;
   logic                      out_end_ff;

   logic [EOB_W-1:0]          eob_max_ff, eob_max_in;

   logic signed [Q_W-1:0]     q_full;
   logic signed [P_W-1:0]     prod2;
   logic signed [P_W-1:0]     half;
   logic [EOB_W-1:0]          cand;
   logic [EOB_W-1:0]          running;
   logic                      nonzero;

   // The whole back end moves together whenever the output stage is empty or being popped.
   assign advance     = !out_valid_ff || pop;
   assign item_take   = advance && item_avail;
   assign s1_valid_in = advance ? item_avail : s1_valid_ff;

   assign prod1 = item.t * item.quant;
   assign m_in  = item.half_mode ? M_W'(prod1 >>> 15) : M_W'(prod1 >>> 16);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_m_ff     <= m_in;
         s1_dqs_ff   <= item.dequant;
         s1_neg_ff   <= item.neg;
         s1_half_ff  <= item.half_mode;
         s1_pos_ff   <= item.pos;
         s1_first_ff <= item.first;
         s1_last_ff  <= item.last;
      end
   end

   assign nonzero = (s1_m_ff != '0);
   assign q_full  = s1_neg_ff ? -Q_W'(s1_m_ff) : Q_W'(s1_m_ff);
   assign prod2   = $signed(q_full[COEFF_W-1:0]) * s1_dqs_ff;
   // Halving in the 32x32 path truncates toward zero.
   assign half    = (prod2 + P_W'(prod2 < 0)) >>> 1;

   assign out_q_in  = q_full[COEFF_W-1:0];
   assign out_dq_in = s1_half_ff ? half[COEFF_W-1:0] : prod2[COEFF_W-1:0];

   always_comb begin
      cand = EOB_W'(s1_pos_ff) + EOB_W'(1);
      if (cand > MAX_COEFFS) begin
         cand = MAX_COEFFS;
      end
      running = s1_first_ff ? '0 : eob_max_ff;
      if (nonzero && (cand > running)) begin
         running = cand;
      end
      out_eob_in = s1_last_ff ? running : '0;
      eob_max_in = eob_max_ff;
      if (advance && s1_valid_ff) begin
         eob_max_in = s1_last_ff ? '0 : running;
      end
   end

   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_q_ff   <= out_q_in;
         out_dq_ff  <= out_dq_in;
         out_eob_ff <= out_eob_in;
         out_end_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         eob_max_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         eob_max_ff   <= eob_max_in;
      end
   end

   assign empty     = !out_valid_ff;
   assign qcoeff    = out_q_ff;
   assign dqcoeff   = out_dq_ff;
   assign eob       = out_eob_ff;
   assign block_end = out_end_ff;

endmodule

`default_nettype wire

[hw/rtl/coeff_quantizer_fp_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Fast-path coefficient quantizer. Coefficients enter one per cycle, while the
// queue is not full, through a queue-style port; each produces one result with
// the quantized and dequantized value, and the item marked last also carries the
// end-of-block value of its block. Sustained rate is one item per clock while
// results are popped: the front end classifies a coefficient (DC or AC
// parameters, magnitude, rounding, saturation, dead zone) in the cycle it is
// pushed and writes it to a QUEUE_DEPTH-entry queue, and the back end runs two
// multipliers, one ahead of the stage-one register and one ahead of the output
// register. The back end holds while a result waits for its pop, and the queue
// keeps taking pushes until it fills. The user must write registers only while
// the block is idle; the block itself does not enforce this.

module coeff_quantizer_fp_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [cqfp_pkg::COEFF_W-1:0]  req_coeff,
   input  logic [cqfp_pkg::POS_W-1:0]           req_scan_pos,
   input  logic                                 req_first,
   input  logic                                 req_last,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [cqfp_pkg::COEFF_W-1:0]  rsp_qcoeff,
   output logic signed [cqfp_pkg::COEFF_W-1:0]  rsp_dqcoeff,
   output logic [cqfp_pkg::EOB_W-1:0]           rsp_eob,
   output logic                                 rsp_block_end,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [4:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import cqfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   work_type   front_item;
   work_type   back_item;
   logic       q_empty;
   logic       q_take;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_MODE:       cfg_in.mode       = pwdata[1:0];
            REG_ROUND_DC:   cfg_in.round_dc   = pwdata[PARAM_W-1:0];
            REG_ROUND_AC:   cfg_in.round_ac   = pwdata[PARAM_W-1:0];
            REG_QUANT_DC:   cfg_in.quant_dc   = pwdata[PARAM_W-1:0];
            REG_QUANT_AC:   cfg_in.quant_ac   = pwdata[PARAM_W-1:0];
            REG_DEQUANT_DC: cfg_in.dequant_dc = pwdata[PARAM_W-1:0];
            REG_DEQUANT_AC: cfg_in.dequant_ac = pwdata[PARAM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MODE:       prdata = {30'd0, cfg_ff.mode};
         REG_ROUND_DC:   prdata = {16'd0, cfg_ff.round_dc};
         REG_ROUND_AC:   prdata = {16'd0, cfg_ff.round_ac};
         REG_QUANT_DC:   prdata = {16'd0, cfg_ff.quant_dc};
         REG_QUANT_AC:   prdata = {16'd0, cfg_ff.quant_ac};
         REG_DEQUANT_DC: prdata = {16'd0, cfg_ff.dequant_dc};
         REG_DEQUANT_AC: prdata = {16'd0, cfg_ff.dequant_ac};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cqfp_front u_front (
      .cfg      (cfg_ff),
      .coeff    (req_coeff),
      .scan_pos (req_scan_pos),
      .first    (req_first),
      .last     (req_last),
      .item     (front_item)
   );

   cqfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_item),
      .full    (full),
      .rd_en   (q_take),
      .rd_data (back_item),
      .empty   (q_empty)
   );

   cqfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_avail (!q_empty),
      .item_take  (q_take),
      .empty      (empty),
      .pop        (pop),
      .qcoeff     (rsp_qcoeff),
      .dqcoeff    (rsp_dqcoeff),
      .eob        (rsp_eob),
      .block_end  (rsp_block_end)
   );

endmodule

`default_nettype wire
